// ----- rtl/core/chs_pkg.sv -----
// Shared constants, codes and types of the chained hash set unit.
package chs_pkg;

   localparam int BUCKETS_DEF = 10;
   localparam int SLOTS_DEF   = 8;

   localparam int KEY_W  = 31;
   localparam int FILL_W = 4;

   // bucket index unit: key bits consumed per cycle
   localparam int MOD_DIGIT  = 4;
   localparam int MOD_STEPS  = (KEY_W + MOD_DIGIT - 1) / MOD_DIGIT;
   localparam int MOD_PAD_W  = MOD_STEPS * MOD_DIGIT;
   localparam int MOD_STEP_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [1:0] STAT_DONE   = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_ABSENT = 2'd2;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [KEY_W-1:0] key;
   } chs_req_item_type;

   typedef struct packed {
      logic              found;
      logic [1:0]        status;
      logic [FILL_W-1:0] bucket_fill;
   } chs_rsp_item_type;

   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] key;
   } chs_mod_cmd_type;

   typedef enum logic [2:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_MOD,
      SEQ_CNT_RD,
      SEQ_DISPATCH,
      SEQ_SCAN,
      SEQ_SHIFT
   } chs_seq_type;

endpackage

// ----- rtl/core/chs_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
module chs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/chs_mod.sv -----
// Iterative key-modulo-BUCKETS unit: MOD_DIGIT key bits per cycle, restoring reduction.
module chs_mod import chs_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEF,
   localparam int RW = $clog2(BUCKETS)
) (
   input  logic            clock,
   input  logic            reset,
   input  chs_mod_cmd_type cmd,
   output logic            done,
   output logic [RW-1:0]   bucket
);

   localparam logic [RW:0] MODULUS = (RW + 1)'(BUCKETS);

   logic [MOD_PAD_W-1:0]  sh_ff, sh_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [MOD_STEP_W-1:0] step_ff, step_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   always_comb begin
      logic [RW:0]   t;
      logic [RW-1:0] r;
      r = rem_ff;
      t = '0;
      // shift in one key bit, then subtract the modulus once if reached
      for (int i = 0; i < MOD_DIGIT; i++) begin
         t = {r, sh_ff[MOD_PAD_W-1-i]};
         if (t >= MODULUS) begin
            t = t - MODULUS;
         end
         r = t[RW-1:0];
      end

      sh_in   = sh_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         sh_in   = {{(MOD_PAD_W-KEY_W){1'b0}}, cmd.key};
         rem_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         sh_in   = sh_ff << MOD_DIGIT;
         rem_in  = r;
         step_in = step_ff + MOD_STEP_W'(1);
         if (step_ff == MOD_STEP_W'(MOD_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

// ----- rtl/core/chained_hash_set_unit.sv -----
// Top level of the chained hash set: request sequencer around the key and count memories.
//
// A hash set of 31-bit keys with separate chaining. A request (insert, delete or search)
// is taken when start is high and busy is low; exactly one result follows, shown on
// rsp_data for a single cycle with rsp_valid high. The result cannot be held off, so the
// receiver must take it in that cycle. The bucket is key modulo BUCKETS, worked out four
// key bits a cycle. The bucket's fill count is then read from the count memory
// and, for delete and search, the bucket's slots are read from the key memory one slot a
// cycle, oldest first. A delete closes the gap by moving each later key down one slot,
// one key a cycle through the single read and single write port of the key memory.
// After reset the count memory is cleared one bucket a cycle, so busy stays high until
// every bucket is cleared, before the first transaction can be taken. Key memory
// contents need no clearing: only slots below the bucket's fill count are ever read.
module chained_hash_set_unit import chs_pkg::*; #(
   parameter int BUCKETS = BUCKETS_DEF,
   parameter int SLOTS   = SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  chs_req_item_type req_data,
   output logic             rsp_valid,
   output chs_rsp_item_type rsp_data
);

   localparam int RW    = $clog2(BUCKETS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int NKEYS = BUCKETS * SLOTS;
   localparam int KA_W  = $clog2(NKEYS);

   // sequencer state
   chs_seq_type      state_ff, state_in;
   logic [RW-1:0]    clr_ff, clr_in;
   chs_req_item_type req_ff, req_in;
   logic [RW-1:0]    bucket_ff, bucket_in;
   logic [KA_W-1:0]  base_ff, base_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic [CW-1:0]    wr_idx_ff, wr_idx_in;
   logic             vld_ff, vld_in;   // key memory output holds slot rd_idx_ff - 1

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   chs_rsp_item_type rsp_ff, rsp_in;
   logic             rsp_found;
   logic [1:0]       rsp_status;
   logic [CW-1:0]    rsp_cnt;
   logic [CW+FILL_W-1:0] fill_ext;

   // modulo unit
   chs_mod_cmd_type  mod_cmd;
   logic             mod_done;
   logic [RW-1:0]    mod_bucket;

   // count memory
   logic             cnt_we, cnt_re;
   logic [RW-1:0]    cnt_waddr, cnt_raddr;
   logic [CW-1:0]    cnt_wdata, cnt_rdata;

   // key memory
   logic             key_we, key_re;
   logic [KA_W-1:0]  key_waddr, key_raddr;
   logic [KEY_W-1:0] key_wdata, key_rdata;

   logic             hit;
   logic             issue;

   assign busy = (state_ff != SEQ_IDLE);

   assign mod_cmd.start = start && (state_ff == SEQ_IDLE);
   assign mod_cmd.key   = req_data.key;

   chs_mod #(.BUCKETS(BUCKETS)) mod_i (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mod_cmd),
      .done   (mod_done),
      .bucket (mod_bucket)
   );

   chs_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) cnt_ram_i (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   chs_ram #(.WIDTH(KEY_W), .DEPTH(NKEYS)) key_ram_i (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_en   (key_re),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   // fill count to the 4-bit result field, masked when SLOTS is wide
   assign fill_ext = {{FILL_W{1'b0}}, rsp_cnt};
   assign rsp_in   = '{found: rsp_found, status: rsp_status,
                       bucket_fill: fill_ext[FILL_W-1:0]};

   assign hit   = vld_ff && (key_rdata == req_ff.key);
   assign issue = (rd_idx_ff < cnt_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      bucket_in    = bucket_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      vld_in       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_found    = 1'b0;
      rsp_status   = STAT_DONE;
      rsp_cnt      = cnt_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = bucket_ff;
      cnt_wdata    = '0;
      cnt_re       = 1'b0;
      cnt_raddr    = bucket_ff;
      key_we       = 1'b0;
      key_waddr    = base_ff + KA_W'(wr_idx_ff);
      key_wdata    = key_rdata;
      key_re       = 1'b0;
      key_raddr    = base_ff + KA_W'(rd_idx_ff);

      unique case (state_ff)
         SEQ_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            if (clr_ff == RW'(BUCKETS - 1)) begin
               state_in = SEQ_IDLE;
            end else begin
               clr_in = clr_ff + RW'(1);
            end
         end
         SEQ_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = SEQ_MOD;
            end
         end
         SEQ_MOD: begin
            if (mod_done) begin
               bucket_in = mod_bucket;
               state_in  = SEQ_CNT_RD;
            end
         end
         SEQ_CNT_RD: begin
            cnt_re   = 1'b1;
            base_in  = KA_W'(bucket_ff * SLOTS);
            state_in = SEQ_DISPATCH;
         end
         SEQ_DISPATCH: begin
            cnt_in    = cnt_rdata;
            rd_idx_in = '0;
            rsp_cnt   = cnt_rdata;
            unique case (req_ff.req_type)
               OP_INSERT: begin
                  rsp_valid_in = 1'b1;
                  state_in     = SEQ_IDLE;
                  if (cnt_rdata >= CW'(SLOTS)) begin
                     rsp_status = STAT_FULL;
                  end else begin
                     // append behind the last held key
                     key_we    = 1'b1;
                     key_waddr = base_ff + KA_W'(cnt_rdata);
                     key_wdata = req_ff.key;
                     cnt_we    = 1'b1;
                     cnt_wdata = cnt_rdata + CW'(1);
                     rsp_cnt   = cnt_rdata + CW'(1);
                  end
               end
               OP_DELETE, OP_SEARCH: begin
                  state_in = SEQ_SCAN;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = SEQ_IDLE;
               end
            endcase
         end
         SEQ_SCAN: begin
            // one slot read issued per cycle, compared as it returns
            key_re    = issue;
            vld_in    = issue;
            rd_idx_in = rd_idx_ff + CW'(issue);
            if (hit) begin
               if (req_ff.req_type == OP_SEARCH) begin
                  rsp_valid_in = 1'b1;
                  rsp_found    = 1'b1;
                  state_in     = SEQ_IDLE;
               end else begin
                  // the read just issued fetches the key after the match
                  wr_idx_in = rd_idx_ff - CW'(1);
                  state_in  = SEQ_SHIFT;
               end
            end else if (!vld_ff && !issue) begin
               rsp_valid_in = 1'b1;
               if (req_ff.req_type == OP_DELETE) begin
                  rsp_status = STAT_ABSENT;
               end
               state_in = SEQ_IDLE;
            end
         end
         SEQ_SHIFT: begin
            // write slot wr_idx with slot wr_idx+1 while reading slot wr_idx+2
            key_re    = issue;
            vld_in    = issue;
            rd_idx_in = rd_idx_ff + CW'(issue);
            if (vld_ff) begin
               key_we    = 1'b1;
               wr_idx_in = wr_idx_ff + CW'(1);
            end else begin
               cnt_we       = 1'b1;
               cnt_wdata    = cnt_ff - CW'(1);
               rsp_cnt      = cnt_ff - CW'(1);
               rsp_valid_in = 1'b1;
               rsp_found    = 1'b1;
               state_in     = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_CLEAR;
         clr_ff       <= '0;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      bucket_ff <= bucket_in;
      base_ff   <= base_in;
      cnt_ff    <= cnt_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/chs_chk.sv -----
// Port-level checker for the chained hash set unit, bound to the top level.
module chs_chk import chs_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input chs_rsp_item_type rsp_data
);

   // reset starts the clearing pass, so the unit refuses transactions
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("unit not busy after reset");

   // an accepted transaction occupies the unit
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit idle right after accepting a transaction");

   // a result strobe is single and only when the unit has gone idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe while busy or without prior work");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a found key always completes normally; failure codes never report found
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.status == STAT_DONE))
      else $error("found result with failure status");

endmodule

bind chained_hash_set_unit chs_chk chk_i (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
